/* hdl/mrf_pkg.sv */
// Shared types, sizes and register codes of the 3x3 median/range filter.
package mrf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int WIN_N      = 9;
  localparam int RANK_W     = 4;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 13;
  localparam int CFG_DATA_W = 13;

  localparam logic MODE_RANGE = 1'b1;

  typedef logic [CH_W-1:0]   chan_t;
  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [RANK_W-1:0] rank_t;

  typedef enum logic [1:0] {
    CFG_MODE   = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_t;

  // Window position of one pixel relative to the image edges
  typedef struct packed {
    logic r_ge1;
    logic r_ge2;
    logic c_ge1;
    logic c_ge2;
    logic r_last;
    logic c_last;
  } pos_t;

endpackage

/* hdl/mrf_ram.sv */
// Generic simple dual-port RAM with registered read.
module mrf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, hold when idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/median_or_range_filter_3x3_core.sv */
// Top level: 3x3 median / range filter over an RGB raster stream.
// Results pass stage 1 (row RAM read), the emitter, the rank stage and the output register.
// Throughput: one pixel per clock unless stalled; extra results of a pixel hold in_tready low.
// The result emitter walks the up to four results of one pixel, one per cycle while r_ready.
// Reset (rst_n low, synchronous) clears counters, window, pipeline valids, and config
// to median mode, 1024 x 4096; the two row RAMs hold no reset and need no clearing pass.
module median_or_range_filter_3x3_core
  import mrf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [PIX_W-1:0]      in_tdata,   // in_red, in_green, in_blue (from bit 0 up)
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [PIX_W-1:0]      out_tdata,  // out_red, out_green, out_blue (from bit 0 up)
  output logic                  out_tlast,  // frame_end
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers
  logic                filter_mode_r;
  logic [WIDTH_W-1:0]  image_width_r;
  logic [HEIGHT_W-1:0] image_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_mode_r  <= 1'b0;
      image_width_r  <= WIDTH_W'(MAX_WIDTH);
      image_height_r <= HEIGHT_W'(MAX_HEIGHT);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MODE:   filter_mode_r  <= cfg_wdata[0];
        CFG_WIDTH:  image_width_r  <= cfg_wdata[WIDTH_W-1:0];
        CFG_HEIGHT: image_height_r <= cfg_wdata[HEIGHT_W-1:0];
        default:    ;
      endcase
    end
  end

  // Clamp frame size, last column and row
  logic [WIDTH_W-1:0]  w_lim;
  logic [HEIGHT_W-1:0] h_lim;
  logic [COL_W-1:0]    wm1;
  logic [ROW_W-1:0]    hm1;

  always_comb begin
    if (image_width_r == '0) w_lim = WIDTH_W'(1);
    else if (image_width_r > WIDTH_W'(MAX_WIDTH)) w_lim = WIDTH_W'(MAX_WIDTH);
    else w_lim = image_width_r;
    if (image_height_r == '0) h_lim = HEIGHT_W'(1);
    else if (image_height_r > HEIGHT_W'(MAX_HEIGHT)) h_lim = HEIGHT_W'(MAX_HEIGHT);
    else h_lim = image_height_r;
    wm1 = COL_W'(w_lim - WIDTH_W'(1));
    hm1 = ROW_W'(h_lim - HEIGHT_W'(1));
  end

  // Position counters
  logic [COL_W-1:0] col_cnt_r, col_cnt_nxt, c_cur;
  logic [ROW_W-1:0] row_cnt_r, row_cnt_nxt, r_cur;
  logic             accept;
  pos_t             pos_cur;

  assign accept = in_tvalid && in_tready;

  always_comb begin
    c_cur = (col_cnt_r < wm1) ? col_cnt_r : wm1;
    r_cur = (row_cnt_r < hm1) ? row_cnt_r : hm1;
    pos_cur.c_last = (c_cur == wm1);
    pos_cur.r_last = (r_cur == hm1);
    pos_cur.c_ge1  = (c_cur >= COL_W'(1));
    pos_cur.c_ge2  = (c_cur >= COL_W'(2));
    pos_cur.r_ge1  = (r_cur >= ROW_W'(1));
    pos_cur.r_ge2  = (r_cur >= ROW_W'(2));
    if (pos_cur.c_last) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = pos_cur.r_last ? '0 : ROW_W'(r_cur + ROW_W'(1));
    end else begin
      col_cnt_nxt = COL_W'(c_cur + COL_W'(1));
      row_cnt_nxt = r_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (accept) begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

  // Stage 1: row RAM read in flight
  logic             s1_v_r;
  pix_t             s1_pix_r;
  logic [COL_W-1:0] s1_c_r;
  pos_t             s1_pos_r;
  logic             s1_fwd_r;
  pix_t             s1_fwd_old_r, s1_fwd_new_r;
  logic             s1_adv;
  pix_t             old_rd, new_rd, oldv, newv;

  assign oldv = s1_fwd_r ? s1_fwd_old_r : old_rd;
  assign newv = s1_fwd_r ? s1_fwd_new_r : new_rd;

  mrf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_c_r),
    .wdata (newv),
    .re    (accept),
    .raddr (c_cur),
    .rdata (old_rd)
  );

  mrf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_newer_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_c_r),
    .wdata (s1_pix_r),
    .re    (accept),
    .raddr (c_cur),
    .rdata (new_rd)
  );

  assign in_tready = !s1_v_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (accept) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  // Capture pixel; forward the write-back that lands in the same cycle as the read
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r     <= in_tdata;
      s1_c_r       <= c_cur;
      s1_pos_r     <= pos_cur;
      s1_fwd_r     <= s1_adv && (s1_c_r == c_cur);
      s1_fwd_old_r <= newv;
      s1_fwd_new_r <= s1_pix_r;
    end
  end

  // Window registers: [row older,newer,current][col C-2,C-1,C]
  pix_t win_r   [3][3];
  pix_t win_nxt [3][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_nxt[i][0] = win_r[i][1];
      win_nxt[i][1] = win_r[i][2];
    end
    win_nxt[0][2] = oldv;
    win_nxt[1][2] = newv;
    win_nxt[2][2] = s1_pix_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else if (s1_adv) begin
      win_r <= win_nxt;
    end
  end

  // Emitter: walk pending results of one pixel in raster order
  logic [3:0] e_mask_r, e_mask_nxt, e_load_mask, e_onehot;
  pix_t       e_win_r [3][3];
  pos_t       e_pos_r;
  logic [1:0] e_sel;
  logic       e_emit, r_ready;

  assign e_load_mask = {s1_pos_r.r_last & s1_pos_r.c_last,
                        s1_pos_r.r_last & s1_pos_r.c_ge1,
                        s1_pos_r.r_ge1  & s1_pos_r.c_last,
                        s1_pos_r.r_ge1  & s1_pos_r.c_ge1};

  always_comb begin
    priority if (e_mask_r[0]) e_sel = 2'd0;
    else if (e_mask_r[1])     e_sel = 2'd1;
    else if (e_mask_r[2])     e_sel = 2'd2;
    else                      e_sel = 2'd3;
    e_onehot   = 4'b0001 << e_sel;
    e_emit     = (e_mask_r != '0) && r_ready;
    e_mask_nxt = e_emit ? (e_mask_r & ~e_onehot) : e_mask_r;
    s1_adv     = s1_v_r && (e_mask_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_mask_r <= '0;
    end else if (s1_adv) begin
      e_mask_r <= e_load_mask;
    end else begin
      e_mask_r <= e_mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      e_win_r <= win_nxt;
      e_pos_r <= s1_pos_r;
    end
  end

  // Samples of the selected result that lie inside the image
  logic [2:0]       row_m, col_m;
  logic [WIN_N-1:0] samp_v;
  logic             top_row, left_col;

  always_comb begin
    top_row  = !e_sel[1];
    left_col = !e_sel[0];
    row_m[0] = top_row && e_pos_r.r_ge2;
    row_m[1] = top_row || e_pos_r.r_ge1;
    row_m[2] = 1'b1;
    col_m[0] = left_col && e_pos_r.c_ge2;
    col_m[1] = left_col || e_pos_r.c_ge1;
    col_m[2] = 1'b1;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        samp_v[i*3+j] = row_m[i] && col_m[j];
      end
    end
  end

  // Rank stage: rank of each sample, outside samples sort last
  logic  r_v_r, r_last_r, o_ready;
  chan_t r_val_r  [3][WIN_N];
  rank_t r_rank_r [3][WIN_N];
  rank_t r_n_r;
  chan_t rk_val   [3][WIN_N];
  rank_t rk_rank  [3][WIN_N];
  rank_t rk_n;

  always_comb begin
    rk_n = '0;
    for (int k = 0; k < WIN_N; k++) begin
      rk_n = rank_t'(rk_n + rank_t'(samp_v[k]));
    end
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < WIN_N; k++) begin
        rk_val[ch][k] = e_win_r[k/3][k%3][ch*CH_W +: CH_W];
      end
    end
    for (int ch = 0; ch < 3; ch++) begin
      for (int i = 0; i < WIN_N; i++) begin
        rk_rank[ch][i] = '0;
        for (int j = 0; j < WIN_N; j++) begin
          if (j != i) begin
            if ((samp_v[j] && !samp_v[i]) ||
                (samp_v[j] == samp_v[i] &&
                 (rk_val[ch][j] < rk_val[ch][i] ||
                  (rk_val[ch][j] == rk_val[ch][i] && j < i)))) begin
              rk_rank[ch][i] = rank_t'(rk_rank[ch][i] + rank_t'(1));
            end
          end
        end
      end
    end
  end

  assign r_ready = !r_v_r || o_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_v_r <= 1'b0;
    end else if (r_ready) begin
      r_v_r <= e_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (e_emit) begin
      r_val_r  <= rk_val;
      r_rank_r <= rk_rank;
      r_n_r    <= rk_n;
      r_last_r <= (e_sel == 2'd3);
    end
  end

  // Output stage: pick by rank, form median or range
  logic       out_tvalid_r, out_tlast_r;
  pix_t       out_tdata_r, res;
  rank_t      k_med, k_max;
  chan_t      v_med, v_max, v_min;

  always_comb begin
    k_max = rank_t'(r_n_r - rank_t'(1));
    k_med = k_max >> 1;
    for (int ch = 0; ch < 3; ch++) begin
      v_med = '0;
      v_max = '0;
      v_min = '0;
      for (int i = 0; i < WIN_N; i++) begin
        if (r_rank_r[ch][i] == k_med) v_med = v_med | r_val_r[ch][i];
        if (r_rank_r[ch][i] == k_max) v_max = v_max | r_val_r[ch][i];
        if (r_rank_r[ch][i] == '0)    v_min = v_min | r_val_r[ch][i];
      end
      res[ch*CH_W +: CH_W] = (filter_mode_r == MODE_RANGE) ? chan_t'(v_max - v_min) : v_med;
    end
  end

  assign o_ready = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (o_ready) begin
      out_tvalid_r <= r_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (o_ready && r_v_r) begin
      out_tdata_r <= res;
      out_tlast_r <= r_last_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

endmodule

/* hdl/mrf_checker.sv */
// Port-level checks of the filter core and their binding.
module mrf_checker
  import mrf_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [PIX_W-1:0] out_tdata,
  input logic             out_tlast
);

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output beat changed");

  // Reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // Reset leaves the input open
  a_rst_ready: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready right after reset");

endmodule

bind median_or_range_filter_3x3_core mrf_checker u_mrf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
